// ===== src/atcw_pkg.sv =====
package atcw_pkg;

    // Screen geometry and parser limits
    localparam int ROWS     = 25;
    localparam int COLS     = 80;
    localparam int MAX_ARGS = 3;
    localparam int NCELLS   = ROWS * COLS;

    // Field widths fixed by the interface
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int CHAR_W = 8;
    localparam int CLR_W  = 4;
    localparam int ARG_W  = 8;
    localparam int CELL_W = CHAR_W + 2 * CLR_W + 1;
    localparam int ADDR_W = $clog2(NCELLS);
    localparam int ACNT_W = $clog2(MAX_ARGS + 1);
    localparam int AIDX_W = (MAX_ARGS > 1) ? $clog2(MAX_ARGS) : 1;

    // Configuration register indexes
    localparam logic [1:0] REG_BS_ENABLE  = 2'd0;
    localparam logic [1:0] REG_DEFAULT_FG = 2'd1;
    localparam logic [1:0] REG_DEFAULT_BG = 2'd2;

    // Reset values
    localparam logic [CLR_W-1:0] RST_FG = 4'd15;
    localparam logic [CLR_W-1:0] RST_BG = 4'd0;

    // Byte codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_LOW_M = 8'h6D;
    localparam logic [7:0] CH_CAP_H = 8'h48;
    localparam logic [7:0] CH_LOW_F = 8'h66;

    // SGR codes
    localparam logic [ARG_W-1:0] SGR_RESET    = 8'd0;
    localparam logic [ARG_W-1:0] SGR_BLINK    = 8'd5;
    localparam logic [ARG_W-1:0] SGR_BLINK_F  = 8'd6;
    localparam logic [ARG_W-1:0] SGR_NO_BLINK = 8'd25;
    localparam logic [ARG_W-1:0] SGR_FG_LO    = 8'd30;
    localparam logic [ARG_W-1:0] SGR_FG_HI    = 8'd37;
    localparam logic [ARG_W-1:0] SGR_BG_LO    = 8'd40;
    localparam logic [ARG_W-1:0] SGR_BG_HI    = 8'd47;

    // Parser phases
    localparam logic [1:0] PH_TEXT    = 2'd0;
    localparam logic [1:0] PH_ESC     = 2'd1;
    localparam logic [1:0] PH_CSI     = 2'd2;
    localparam logic [1:0] PH_CSI_DIG = 2'd3;

    // Cell layout: {blink, bg, fg, char}
    typedef struct packed {
        logic             blink;
        logic [CLR_W-1:0] bg;
        logic [CLR_W-1:0] fg;
        logic [CHAR_W-1:0] ch;
    } cell_t;

    // Request from the sequencer to the cell store
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        cell_t             wdata;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        logic [ADDR_W-1:0] base;
        base = ADDR_W'(row) * ADDR_W'(COLS);
        return base + ADDR_W'(col);
    endfunction

endpackage

// ===== src/atcw_screen.sv =====
module atcw_screen
    import atcw_pkg::*;
(
    input  logic     clk,
    input  ram_req_t req,
    output cell_t    rdata
);

    cell_t mem [NCELLS];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata <= mem[req.raddr];
    end

endmodule

// ===== src/ansi_text_console_writer_top.sv =====
// ANSI text console writer.
// Input channel (in_valid/in_ready): operation 0 feeds byte_in to the escape
// parser and screen writer; operation 1 reads the cell at read_row/read_col.
// Output channel (out_valid/out_ready): one transfer per input item, carrying
// the cursor after the item and, for reads, the cell (zero for byte items).
// Config port: cfg_write with cfg_index/cfg_data sets backspace enable and the
// default colours; write only while the block is idle.
// Sequencing: one item at a time through a sequencer around a cell store
// with separate read and write addresses (one write, one registered read per
// cycle). Tab reads and rewrites each cell up to the tab stop as a space;
// backspace from column 0 reads each cell that it walks back over; a scroll at
// the bottom line reads and rewrites every cell of the store.
// Reset: the cell store is swept to spaces with white on black, one cell per
// cycle; in_ready stays low meanwhile.
// Stall: a finished result waits in the output register; the next item is
// accepted meanwhile and holds in its last step until the output drains.
module ansi_text_console_writer_top
    import atcw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              operation,
    input  logic [7:0]        byte_in,
    input  logic [ROW_W-1:0]  read_row,
    input  logic [COL_W-1:0]  read_col,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [ROW_W-1:0]  cursor_row,
    output logic [COL_W-1:0]  cursor_col,
    output logic [CHAR_W-1:0] cell_char,
    output logic [CLR_W-1:0]  cell_fg,
    output logic [CLR_W-1:0]  cell_bg,
    output logic              cell_blink,
    input  logic              cfg_write,
    input  logic [1:0]        cfg_index,
    input  logic [CLR_W-1:0]  cfg_data
);

    typedef enum logic [14:0] {
        S_CLEAR = 15'b000000000000001,
        S_IDLE  = 15'b000000000000010,
        S_DISP  = 15'b000000000000100,
        S_RD    = 15'b000000000001000,
        S_BS_A  = 15'b000000000010000,
        S_BS_B  = 15'b000000000100000,
        S_BS_W  = 15'b000000001000000,
        S_BS_C  = 15'b000000010000000,
        S_TAB_R = 15'b000000100000000,
        S_TAB_W = 15'b000001000000000,
        S_SC_R  = 15'b000010000000000,
        S_SC_W  = 15'b000100000000000,
        S_SGR   = 15'b001000000000000,
        S_PLACE = 15'b010000000000000,
        S_DONE  = 15'b100000000000000
    } state_t;

    localparam logic [ADDR_W-1:0] LAST_ROW_BASE = ADDR_W'((ROWS - 1) * COLS);
    localparam logic [ADDR_W-1:0] LAST_CELL     = ADDR_W'(NCELLS - 1);
    localparam logic [ROW_W-1:0]  ROW_MAX       = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0]  COL_MAX       = COL_W'(COLS - 1);

    state_t state_reg, state_next;

    // Configuration
    logic             bs_en_reg;
    logic [CLR_W-1:0] dflt_fg_reg, dflt_bg_reg;

    // Terminal state
    logic [ROW_W-1:0] row_reg, row_next, srow_reg, srow_next;
    logic [COL_W-1:0] col_reg, col_next, scol_reg, scol_next;
    logic [CLR_W-1:0] fg_reg, fg_next, bg_reg, bg_next;
    logic             blink_reg, blink_next;
    logic [1:0]       phase_reg, phase_next;
    logic [ARG_W-1:0] args_reg [MAX_ARGS];
    logic [ARG_W-1:0] args_next [MAX_ARGS];
    logic [ACNT_W-1:0] acnt_reg, acnt_next;
    logic [ARG_W-1:0] accum_reg, accum_next;

    // Item and sequencer working registers
    logic             op_reg;
    logic [7:0]       byte_reg;
    logic [ROW_W-1:0] rrow_reg;
    logic [COL_W-1:0] rcol_reg;
    logic [ADDR_W-1:0] ptr_reg, ptr_next;
    logic [ROW_W-1:0] prow_reg, prow_next;
    logic [COL_W-1:0] pcol_reg, pcol_next;
    logic [COL_W-1:0] tcol_reg, tcol_next;
    logic [CHAR_W-1:0] tch_reg, tch_next;
    logic [ACNT_W-1:0] aidx_reg, aidx_next;
    cell_t            res_reg, res_next;

    // Output register
    logic             ovalid_reg;
    logic [ROW_W-1:0] orow_reg;
    logic [COL_W-1:0] ocol_reg;
    cell_t            ocell_reg;

    ram_req_t ram_req;
    cell_t    ram_rdata;

    logic [ADDR_W-1:0] cur_addr;
    logic              in_xfer;
    logic              out_free;
    logic              do_store;
    logic [ARG_W-1:0]  sgr_arg;
    logic [ARG_W-1:0]  accum_x10;
    logic [COL_W:0]    tab_stop;

    atcw_screen u_screen (
        .clk   (clk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    assign in_ready   = (state_reg == S_IDLE);
    assign in_xfer    = in_valid && in_ready;
    assign out_free   = !ovalid_reg || out_ready;
    assign cur_addr   = cell_addr(row_reg, col_reg);
    assign accum_x10  = ARG_W'({accum_reg, 3'b000}) + ARG_W'({accum_reg, 1'b0});
    assign tab_stop   = {1'b0, col_reg[COL_W-1:3] + 1'b1, 3'b000};
    assign sgr_arg    = args_reg[aidx_reg[AIDX_W-1:0]];

    assign out_valid  = ovalid_reg;
    assign cursor_row = orow_reg;
    assign cursor_col = ocol_reg;
    assign cell_char  = ocell_reg.ch;
    assign cell_fg    = ocell_reg.fg;
    assign cell_bg    = ocell_reg.bg;
    assign cell_blink = ocell_reg.blink;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bs_en_reg   <= 1'b0;
            dflt_fg_reg <= RST_FG;
            dflt_bg_reg <= RST_BG;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_BS_ENABLE:  bs_en_reg   <= cfg_data[0];
                REG_DEFAULT_FG: dflt_fg_reg <= cfg_data;
                REG_DEFAULT_BG: dflt_bg_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        srow_next  = srow_reg;
        scol_next  = scol_reg;
        fg_next    = fg_reg;
        bg_next    = bg_reg;
        blink_next = blink_reg;
        phase_next = phase_reg;
        args_next  = args_reg;
        acnt_next  = acnt_reg;
        accum_next = accum_reg;
        ptr_next   = ptr_reg;
        prow_next  = prow_reg;
        pcol_next  = pcol_reg;
        tcol_next  = tcol_reg;
        tch_next   = tch_reg;
        aidx_next  = aidx_reg;
        res_next   = res_reg;
        do_store   = 1'b0;

        ram_req       = '0;
        ram_req.raddr = cur_addr;

        case (state_reg)
            S_CLEAR:
            begin
                // Sweep the store to blank cells after reset
                ram_req.we    = 1'b1;
                ram_req.waddr = ptr_reg;
                ram_req.wdata = '{blink: 1'b0, bg: RST_BG, fg: RST_FG, ch: CH_SPACE};
                ptr_next      = ptr_reg + 1'b1;
                if (ptr_reg == LAST_CELL)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = S_DISP;
                end
            end

            S_DISP:
            begin
                res_next   = '0;
                state_next = S_DONE;
                if (op_reg)
                begin
                    if (rrow_reg < ROW_W'(ROWS) && rcol_reg < COL_W'(COLS))
                    begin
                        ram_req.raddr = cell_addr(rrow_reg, rcol_reg);
                        state_next    = S_RD;
                    end
                end
                else if (phase_reg == PH_TEXT)
                begin
                    case (byte_reg)
                        CH_ESC: phase_next = PH_ESC;
                        CH_NUL: ;
                        CH_CR:  col_next = '0;
                        CH_BS:
                        begin
                            if (bs_en_reg && (row_reg != '0 || col_reg != '0))
                            begin
                                state_next = S_BS_A;
                            end
                        end
                        CH_TAB:
                        begin
                            tcol_next = (tab_stop >= (COL_W + 1)'(COLS)) ? COL_MAX
                                                                         : tab_stop[COL_W-1:0];
                            if (tcol_next != col_reg)
                            begin
                                state_next = S_TAB_R;
                            end
                        end
                        CH_LF:
                        begin
                            col_next = '0;
                            if (row_reg < ROW_MAX)
                            begin
                                row_next = row_reg + 1'b1;
                            end
                            else
                            begin
                                ptr_next   = '0;
                                state_next = S_SC_R;
                            end
                        end
                        default:
                        begin
                            // Printable or unhandled control: write a full cell
                            ram_req.we    = 1'b1;
                            ram_req.waddr = cur_addr;
                            ram_req.wdata = '{blink: blink_reg, bg: bg_reg, fg: fg_reg,
                                              ch: byte_reg};
                            if (col_reg < COL_MAX)
                            begin
                                col_next = col_reg + 1'b1;
                            end
                            else
                            begin
                                col_next = '0;
                                if (row_reg < ROW_MAX)
                                begin
                                    row_next = row_reg + 1'b1;
                                end
                                else
                                begin
                                    ptr_next   = '0;
                                    state_next = S_SC_R;
                                end
                            end
                        end
                    endcase
                end
                else if (phase_reg == PH_ESC)
                begin
                    if (byte_reg == CH_LBRK)
                    begin
                        phase_next = PH_CSI;
                        acnt_next  = '0;
                        accum_next = '0;
                    end
                    else
                    begin
                        phase_next = PH_TEXT;
                    end
                end
                else
                begin
                    if (byte_reg >= CH_ZERO && byte_reg <= CH_NINE)
                    begin
                        accum_next = accum_x10 + (byte_reg - CH_ZERO);
                        phase_next = PH_CSI_DIG;
                    end
                    else if (byte_reg == CH_SEMI)
                    begin
                        do_store = 1'b1;
                    end
                    else if (byte_reg == CH_LOW_M)
                    begin
                        do_store   = 1'b1;
                        aidx_next  = '0;
                        state_next = S_SGR;
                    end
                    else if (byte_reg == CH_CAP_H || byte_reg == CH_LOW_F)
                    begin
                        do_store   = 1'b1;
                        state_next = S_PLACE;
                    end
                    else
                    begin
                        phase_next = PH_TEXT;
                    end
                    if (do_store)
                    begin
                        // Keep a pending argument, drop extras
                        if (phase_reg == PH_CSI_DIG && acnt_reg < ACNT_W'(MAX_ARGS))
                        begin
                            args_next[acnt_reg[AIDX_W-1:0]] = accum_reg;
                            acnt_next = acnt_reg + 1'b1;
                        end
                        accum_next = '0;
                        phase_next = (byte_reg == CH_SEMI) ? PH_CSI : PH_TEXT;
                    end
                end
            end

            S_RD:
            begin
                res_next   = ram_rdata;
                state_next = S_DONE;
            end

            S_BS_A:
            begin
                // Hold the cursor cell's character, fetch the cell before it
                tch_next      = ram_rdata.ch;
                ram_req.raddr = cur_addr - 1'b1;
                state_next    = S_BS_B;
            end

            S_BS_B:
            begin
                ram_req.we       = 1'b1;
                ram_req.waddr    = cur_addr - 1'b1;
                ram_req.wdata    = ram_rdata;
                ram_req.wdata.ch = tch_reg;
                if (col_reg != '0)
                begin
                    col_next   = col_reg - 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    ptr_next   = cur_addr - 1'b1;
                    prow_next  = row_reg - 1'b1;
                    pcol_next  = COL_MAX;
                    state_next = S_BS_W;
                end
            end

            S_BS_W:
            begin
                ram_req.raddr = ptr_reg;
                state_next    = S_BS_C;
            end

            S_BS_C:
            begin
                // Walk back over the run of spaces
                state_next = S_DONE;
                if (ram_rdata.ch == CH_SPACE)
                begin
                    row_next = prow_reg;
                    col_next = pcol_reg;
                    if (ptr_reg != '0)
                    begin
                        ptr_next = ptr_reg - 1'b1;
                        if (pcol_reg == '0)
                        begin
                            pcol_next = COL_MAX;
                            prow_next = prow_reg - 1'b1;
                        end
                        else
                        begin
                            pcol_next = pcol_reg - 1'b1;
                        end
                        state_next = S_BS_W;
                    end
                end
            end

            S_TAB_R:
            begin
                state_next = S_TAB_W;
            end

            S_TAB_W:
            begin
                ram_req.we       = 1'b1;
                ram_req.waddr    = cur_addr;
                ram_req.wdata    = ram_rdata;
                ram_req.wdata.ch = CH_SPACE;
                col_next         = col_reg + 1'b1;
                state_next       = (col_next == tcol_reg) ? S_DONE : S_TAB_R;
            end

            S_SC_R:
            begin
                ram_req.raddr = (ptr_reg < LAST_ROW_BASE) ? ptr_reg + ADDR_W'(COLS) : ptr_reg;
                state_next    = S_SC_W;
            end

            S_SC_W:
            begin
                // Move a row up; blank characters of the last row in place
                ram_req.we    = 1'b1;
                ram_req.waddr = ptr_reg;
                ram_req.wdata = ram_rdata;
                if (ptr_reg >= LAST_ROW_BASE)
                begin
                    ram_req.wdata.ch = CH_SPACE;
                end
                ptr_next = ptr_reg + 1'b1;
                state_next = (ptr_reg == LAST_CELL) ? S_DONE : S_SC_R;
            end

            S_SGR:
            begin
                if (aidx_reg < acnt_reg)
                begin
                    if (sgr_arg >= SGR_FG_LO && sgr_arg <= SGR_FG_HI)
                    begin
                        fg_next = CLR_W'(sgr_arg - SGR_FG_LO);
                    end
                    else if (sgr_arg >= SGR_BG_LO && sgr_arg <= SGR_BG_HI)
                    begin
                        bg_next = CLR_W'(sgr_arg - SGR_BG_LO);
                    end
                    else if (sgr_arg == SGR_BLINK || sgr_arg == SGR_BLINK_F)
                    begin
                        blink_next = 1'b1;
                    end
                    else if (sgr_arg == SGR_NO_BLINK)
                    begin
                        blink_next = 1'b0;
                    end
                    else if (sgr_arg == SGR_RESET)
                    begin
                        fg_next    = dflt_fg_reg;
                        bg_next    = dflt_bg_reg;
                        blink_next = 1'b0;
                    end
                    aidx_next = aidx_reg + 1'b1;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_PLACE:
            begin
                if (acnt_reg == ACNT_W'(2))
                begin
                    srow_next = row_reg;
                    scol_next = col_reg;
                    row_next  = (args_reg[0] < ARG_W'(ROWS)) ? ROW_W'(args_reg[0]) : ROW_MAX;
                    col_next  = (args_reg[1] < ARG_W'(COLS)) ? COL_W'(args_reg[1]) : COL_MAX;
                end
                else if (acnt_reg == ACNT_W'(1) && args_reg[0] == '0)
                begin
                    row_next = srow_reg;
                    col_next = scol_reg;
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and terminal state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            ptr_reg   <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
            srow_reg  <= '0;
            scol_reg  <= '0;
            fg_reg    <= RST_FG;
            bg_reg    <= RST_BG;
            blink_reg <= 1'b0;
            phase_reg <= PH_TEXT;
            acnt_reg  <= '0;
            accum_reg <= '0;
            aidx_reg  <= '0;
            for (int i = 0; i < MAX_ARGS; i++)
            begin
                args_reg[i] <= '0;
            end
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            srow_reg  <= srow_next;
            scol_reg  <= scol_next;
            fg_reg    <= fg_next;
            bg_reg    <= bg_next;
            blink_reg <= blink_next;
            phase_reg <= phase_next;
            acnt_reg  <= acnt_next;
            accum_reg <= accum_next;
            aidx_reg  <= aidx_next;
            args_reg  <= args_next;
            if (state_reg == S_DONE && out_free)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        prow_reg <= prow_next;
        pcol_reg <= pcol_next;
        tcol_reg <= tcol_next;
        tch_reg  <= tch_next;
        res_reg  <= res_next;
        if (in_xfer)
        begin
            op_reg   <= operation;
            byte_reg <= byte_in;
            rrow_reg <= read_row;
            rcol_reg <= read_col;
        end
        if (state_reg == S_DONE && out_free)
        begin
            orow_reg  <= row_reg;
            ocol_reg  <= col_reg;
            ocell_reg <= res_reg;
        end
    end

`ifndef ASSERT_OFF
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg <= ROW_MAX && col_reg <= COL_MAX)
        else $error("cursor left the screen");

    a_arg_count: assert property (@(posedge clk) disable iff (!rst_n)
        acnt_reg <= ACNT_W'(MAX_ARGS))
        else $error("argument count overflow");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !in_ready)
        else $error("accepted an item while busy");

    a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_free) |=> ovalid_reg)
        else $error("result lost");
`endif

endmodule

// ===== verif/tb.sv =====
module tb;
    import atcw_pkg::*;

    // One input item as the driver presents it
    typedef struct {
        logic              op;
        logic [7:0]        code;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
    } term_item_t;

    // One result transfer as the block should produce it
    typedef struct {
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [CHAR_W-1:0] ch;
        logic [CLR_W-1:0]  fg;
        logic [CLR_W-1:0]  bg;
        logic              blink;
    } screen_view_t;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_READ = 1'b1;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic              operation;
    logic [7:0]        byte_in;
    logic [ROW_W-1:0]  read_row;
    logic [COL_W-1:0]  read_col;
    logic              out_valid;
    logic              out_ready;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
    logic [CHAR_W-1:0] cell_char;
    logic [CLR_W-1:0]  cell_fg;
    logic [CLR_W-1:0]  cell_bg;
    logic              cell_blink;
    logic              cfg_write;
    logic [1:0]        cfg_index;
    logic [CLR_W-1:0]  cfg_data;

    ansi_text_console_writer_top DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .byte_in    (byte_in),
        .read_row   (read_row),
        .read_col   (read_col),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .cursor_row (cursor_row),
        .cursor_col (cursor_col),
        .cell_char  (cell_char),
        .cell_fg    (cell_fg),
        .cell_bg    (cell_bg),
        .cell_blink (cell_blink),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // ------------------------------------------------------------------
    // Screen predictor state: cell store, cursor, attributes, parser
    // ------------------------------------------------------------------
    cell_t             screen_q [NCELLS];
    int                cur_row, cur_col, mark_row, mark_col;
    logic [CLR_W-1:0]  pen_fg, pen_bg;
    logic              pen_blink;
    logic [1:0]        parse_ph;
    logic [ARG_W-1:0]  csi_args [MAX_ARGS];
    int                csi_nargs;
    logic [ARG_W-1:0]  csi_acc;
    logic              bs_on;
    logic [CLR_W-1:0]  dflt_fg, dflt_bg;

    term_item_t        stim_q [$];
    screen_view_t      view_q [$];

    int send_idle, recv_idle;
    logic hold_off;
    logic took;
    int mismatches, fails, n_items, n_reads, n_scrolls, n_results;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    task automatic scroll_screen();
        for (int i = 0; i < (ROWS - 1) * COLS; i++)
            screen_q[i] = screen_q[i + COLS];
        for (int i = 0; i < COLS; i++)
            screen_q[(ROWS - 1) * COLS + i].ch = CH_SPACE;
        n_scrolls++;
    endtask

    task automatic line_feed();
        if (cur_row + 1 < ROWS) cur_row++;
        else scroll_screen();
        cur_col = 0;
    endtask

    task automatic write_glyph(input logic [7:0] c);
        int p;
        p = cur_row * COLS + cur_col;
        screen_q[p].ch    = c;
        screen_q[p].fg    = pen_fg;
        screen_q[p].bg    = pen_bg;
        screen_q[p].blink = pen_blink;
        if (cur_col + 1 < COLS) cur_col++;
        else line_feed();
    endtask

    task automatic erase_back();
        int p, steps, i;
        p = cur_row * COLS + cur_col;
        if (!bs_on || p == 0) return;
        screen_q[p - 1].ch = screen_q[p].ch;
        if (cur_col != 0) steps = 1;
        else begin
            // walk back over the run of spaces ending left of the cursor
            steps = 0;
            i = p - 1;
            while (screen_q[i].ch == CH_SPACE) begin
                steps++;
                if (i == 0) break;
                i--;
            end
        end
        p -= steps;
        cur_row = p / COLS;
        cur_col = p % COLS;
    endtask

    task automatic tab_stop();
        int n;
        n = 8 - (cur_col % 8);
        if (cur_col + n >= COLS) n = COLS - cur_col - 1;
        for (int i = 0; i < n; i++)
            screen_q[cur_row * COLS + cur_col + i].ch = CH_SPACE;
        cur_col += n;
    endtask

    task automatic latch_arg();
        if (parse_ph == PH_CSI_DIG && csi_nargs < MAX_ARGS) begin
            csi_args[csi_nargs] = csi_acc;
            csi_nargs++;
        end
        csi_acc  = '0;
        parse_ph = PH_CSI;
    endtask

    task automatic apply_sgr();
        logic [ARG_W-1:0] a;
        for (int i = 0; i < csi_nargs; i++) begin
            a = csi_args[i];
            if (a >= SGR_FG_LO && a <= SGR_FG_HI) pen_fg = CLR_W'(a - SGR_FG_LO);
            else if (a >= SGR_BG_LO && a <= SGR_BG_HI) pen_bg = CLR_W'(a - SGR_BG_LO);
            else if (a == SGR_BLINK || a == SGR_BLINK_F) pen_blink = 1'b1;
            else if (a == SGR_NO_BLINK) pen_blink = 1'b0;
            else if (a == SGR_RESET) begin
                pen_fg    = dflt_fg;
                pen_bg    = dflt_bg;
                pen_blink = 1'b0;
            end
        end
    endtask

    task automatic apply_place();
        if (csi_nargs == 2) begin
            mark_row = cur_row;
            mark_col = cur_col;
            cur_row  = (csi_args[0] < ROWS) ? int'(csi_args[0]) : ROWS - 1;
            cur_col  = (csi_args[1] < COLS) ? int'(csi_args[1]) : COLS - 1;
        end else if (csi_nargs == 1 && csi_args[0] == 0) begin
            cur_row = mark_row;
            cur_col = mark_col;
        end
    endtask

    task automatic feed_byte(input logic [7:0] c);
        if (parse_ph == PH_TEXT) begin
            case (c)
                CH_ESC:  parse_ph = PH_ESC;
                CH_BS:   erase_back();
                CH_TAB:  tab_stop();
                CH_NUL:  ;
                CH_CR:   cur_col = 0;
                CH_LF:   line_feed();
                default: write_glyph(c);
            endcase
        end else if (parse_ph == PH_ESC) begin
            if (c == CH_LBRK) begin
                parse_ph  = PH_CSI;
                csi_nargs = 0;
                csi_acc   = '0;
            end else parse_ph = PH_TEXT;
        end else begin
            if (c >= CH_ZERO && c <= CH_NINE) begin
                csi_acc  = ARG_W'(csi_acc * 10 + (c - CH_ZERO));
                parse_ph = PH_CSI_DIG;
            end else if (c == CH_SEMI) latch_arg();
            else if (c == CH_LOW_M || c == CH_CAP_H || c == CH_LOW_F) begin
                latch_arg();
                if (c == CH_LOW_M) apply_sgr();
                else apply_place();
                parse_ph = PH_TEXT;
            end else parse_ph = PH_TEXT;
        end
    endtask

    // Work out the result of one accepted item and queue it
    task automatic predict_screen(input term_item_t it);
        screen_view_t v;
        v = '{row: '0, col: '0, ch: '0, fg: '0, bg: '0, blink: 1'b0};
        if (it.op == OP_BYTE) feed_byte(it.code);
        else begin
            n_reads++;
            if (it.row < ROWS && it.col < COLS) begin
                v.ch    = screen_q[it.row * COLS + it.col].ch;
                v.fg    = screen_q[it.row * COLS + it.col].fg;
                v.bg    = screen_q[it.row * COLS + it.col].bg;
                v.blink = screen_q[it.row * COLS + it.col].blink;
            end
        end
        v.row = ROW_W'(cur_row);
        v.col = COL_W'(cur_col);
        view_q.push_back(v);
        n_items++;
    endtask

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    task automatic add_byte(input logic [7:0] c);
        term_item_t it;
        it.op   = OP_BYTE;
        it.code = c;
        it.row  = ROW_W'($urandom);
        it.col  = COL_W'($urandom);
        stim_q.push_back(it);
    endtask

    task automatic add_read(input int r, input int c);
        term_item_t it;
        it.op   = OP_READ;
        it.code = 8'($urandom);
        it.row  = ROW_W'(r);
        it.col  = COL_W'(c);
        stim_q.push_back(it);
    endtask

    // Decimal digits of n, sometimes with a leading zero
    task automatic add_number(input int n);
        if ($urandom_range(9) == 0) add_byte(CH_ZERO);
        if (n >= 100) add_byte(8'(CH_ZERO + n / 100));
        if (n >= 10) add_byte(8'(CH_ZERO + (n / 10) % 10));
        add_byte(8'(CH_ZERO + n % 10));
    endtask

    task automatic add_csi_head();
        add_byte(CH_ESC);
        add_byte(CH_LBRK);
    endtask

    function automatic int pick_sgr_code();
        int k;
        k = $urandom_range(9);
        if (k < 4) return $urandom_range(47, 30);
        if (k == 4) return SGR_RESET;
        if (k == 5) return $urandom_range(1) ? SGR_BLINK : SGR_BLINK_F;
        if (k == 6) return SGR_NO_BLINK;
        return $urandom_range(999);
    endfunction

    task automatic add_random_group();
        int k, n;
        k = $urandom_range(99);
        if (k < 33) begin
            // text run, mostly printable
            n = $urandom_range(8, 1);
            for (int i = 0; i < n; i++)
                add_byte($urandom_range(3) == 0 ? 8'($urandom) : 8'($urandom_range(126, 32)));
        end else if (k < 48) begin
            // SGR with up to four arguments, empty ones now and then
            add_csi_head();
            n = $urandom_range(4);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(7) != 0) add_number(pick_sgr_code());
                if (i != n - 1) add_byte(CH_SEMI);
            end
            add_byte(CH_LOW_M);
        end else if (k < 60) begin
            // placement: two arguments, restore, or odd counts
            add_csi_head();
            n = $urandom_range(9);
            if (n < 6) begin
                add_number($urandom_range(3) == 0 ? $urandom_range(999) : $urandom_range(30));
                add_byte(CH_SEMI);
                add_number($urandom_range(3) == 0 ? $urandom_range(999) : $urandom_range(90));
            end else if (n < 8) add_number($urandom_range(3) == 0 ? 1 : 0);
            else if (n == 8) begin
                add_number(1);
                add_byte(CH_SEMI);
                add_number(2);
                add_byte(CH_SEMI);
                add_number(3);
            end
            add_byte($urandom_range(1) ? CH_CAP_H : CH_LOW_F);
        end else if (k < 76) begin
            if ($urandom_range(4) == 0) add_read($urandom_range(31), $urandom_range(127));
            else add_read($urandom_range(ROWS - 1), $urandom_range(COLS - 1));
        end else if (k < 88) begin
            n = $urandom_range(9);
            case (n)
                0, 1, 2: add_byte(CH_BS);
                3, 4:    add_byte(CH_TAB);
                5, 6:    add_byte(CH_CR);
                7:       add_byte(CH_NUL);
                default: add_byte($urandom_range(3) == 0 ? CH_LF : CH_CR);
            endcase
        end else if (k < 95) begin
            // broken sequences: a stray byte after ESC or inside CSI
            add_byte(CH_ESC);
            if ($urandom_range(1)) add_byte(8'($urandom));
            else begin
                add_byte(CH_LBRK);
                if ($urandom_range(1)) add_number($urandom_range(99));
                add_byte(8'($urandom));
            end
        end else add_byte(8'($urandom));
    endtask

    task automatic add_random_items(input int count);
        int start;
        start = stim_q.size();
        while (stim_q.size() - start < count) add_random_group();
    endtask

    // Short directed opening: field extremes, controls, each special case
    task automatic add_directed();
        add_byte(8'hFF);
        add_byte(8'h01);        // control code written as a cell
        add_byte(CH_NUL);
        add_byte(CH_BS);        // disabled at this point
        add_byte(CH_TAB);
        add_byte(CH_CR);
        add_byte(CH_LF);
        add_byte(CH_ESC);
        add_byte(8'h78);        // unknown byte after ESC aborts
        add_csi_head();
        add_number(31); add_byte(CH_SEMI); add_number(42); add_byte(CH_SEMI);
        add_number(5); add_byte(CH_SEMI); add_number(0); add_byte(CH_LOW_M);
        add_csi_head();
        add_number(255); add_byte(CH_SEMI); add_number(255); add_byte(CH_CAP_H);
        add_byte(8'h51);        // last cell of last row: overflow scroll
        add_csi_head();
        add_number(0); add_byte(CH_LOW_F);
        add_read(ROWS - 1, COLS - 1);
        add_read(31, 127);
        add_read(0, 0);
    endtask

    task automatic set_register(input logic [1:0] idx, input logic [CLR_W-1:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_BS_ENABLE:  bs_on   = val[0];
            REG_DEFAULT_FG: dflt_fg = val;
            REG_DEFAULT_BG: dflt_bg = val;
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // Hold until every item is in and every result is out
    task automatic drain();
        while (stim_q.size() != 0 || in_valid || view_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Clock, reset and predictor reset
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n     = 1'b0;
        cfg_write = 1'b0;
        cfg_index = REG_BS_ENABLE;
        cfg_data  = '0;
        bs_on     = 1'b0;
        dflt_fg   = RST_FG;
        dflt_bg   = RST_BG;
        for (int i = 0; i < NCELLS; i++)
            screen_q[i] = '{blink: 1'b0, bg: RST_BG, fg: RST_FG, ch: CH_SPACE};
        cur_row = 0; cur_col = 0; mark_row = 0; mark_col = 0;
        pen_fg = RST_FG; pen_bg = RST_BG; pen_blink = 1'b0;
        parse_ph = PH_TEXT; csi_nargs = 0; csi_acc = '0;
        for (int i = 0; i < MAX_ARGS; i++) csi_args[i] = '0;
        mismatches = 0; fails = 0; n_items = 0; n_reads = 0; n_scrolls = 0;
        n_results = 0;
        send_idle = 30;
        recv_idle = 65;
        hold_off  = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // ------------------------------------------------------------------
    // Driver: present the next pending item at the falling edge
    // ------------------------------------------------------------------
    always @(posedge clk) took <= in_valid && in_ready;

    always @(negedge clk)
    begin : drive_items
        term_item_t it;
        if (!rst_n) begin
            in_valid  <= 1'b0;
            operation <= OP_BYTE;
            byte_in   <= '0;
            read_row  <= '0;
            read_col  <= '0;
        end else if (!in_valid || took) begin
            if (stim_q.size() != 0 && $urandom_range(99) >= send_idle) begin
                it = stim_q.pop_front();
                in_valid  <= 1'b1;
                operation <= it.op;
                byte_in   <= it.code;
                read_row  <= it.row;
                read_col  <= it.col;
            end else in_valid <= 1'b0;
        end
    end

    // Receiver: random stalls, plus a forced hold-off when asked
    always @(negedge clk)
    begin
        if (!rst_n) out_ready <= 1'b0;
        else out_ready <= !hold_off && ($urandom_range(99) >= recv_idle);
    end

    // ------------------------------------------------------------------
    // Monitor: predict on every accepted item, check every result transfer
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : watch
        term_item_t it;
        screen_view_t want;
        if (rst_n && in_valid && in_ready) begin
            it = '{op: operation, code: byte_in, row: read_row, col: read_col};
            predict_screen(it);
        end
        if (rst_n && out_valid && out_ready) begin
            n_results++;
            if (view_q.size() == 0) begin
                fails++;
                $display("[%0t] unexpected result transfer: row %0d col %0d", $realtime,
                         cursor_row, cursor_col);
            end else begin
                want = view_q.pop_front();
                if (want.row !== cursor_row || want.col !== cursor_col ||
                    want.ch !== cell_char || want.fg !== cell_fg ||
                    want.bg !== cell_bg || want.blink !== cell_blink) begin
                    mismatches++;
                    fails++;
                    if (mismatches <= 10)
                        $display("[%0t] result %0d mismatch: exp r%0d c%0d ch%h fg%0d bg%0d b%0d, got r%0d c%0d ch%h fg%0d bg%0d b%0d",
                                 $realtime, n_results, want.row, want.col, want.ch, want.fg,
                                 want.bg, want.blink, cursor_row, cursor_col, cell_char,
                                 cell_fg, cell_bg, cell_blink);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        @(posedge rst_n);
        // wait out the clear sweep before touching the registers
        while (!in_ready) @(posedge clk);

        // Phase 1: reset-value registers, sender idles less than receiver
        set_register(REG_BS_ENABLE, '0);
        set_register(REG_DEFAULT_FG, RST_FG);
        set_register(REG_DEFAULT_BG, RST_BG);
        end_writes();
        add_directed();
        add_random_items(700);
        drain();

        // Phase 2: backspace on, colour extremes swapped, idling reversed
        send_idle = 65;
        recv_idle = 30;
        set_register(REG_BS_ENABLE, 4'd1);
        set_register(REG_DEFAULT_FG, 4'd0);
        set_register(REG_DEFAULT_BG, 4'd15);
        end_writes();
        add_byte(CH_CR);
        add_byte(CH_BS);        // column 0: walk back over spaces
        add_csi_head();
        add_number(0); add_byte(CH_SEMI); add_number(0); add_byte(CH_CAP_H);
        add_byte(CH_BS);        // at the first cell: ignored
        add_csi_head();
        add_number(0); add_byte(CH_LOW_M);
        add_random_items(700);
        drain();

        // Phase 3: mid-range defaults, no idling, one long receiver hold-off
        send_idle = 0;
        recv_idle = 0;
        set_register(REG_DEFAULT_FG, 4'd7);
        set_register(REG_DEFAULT_BG, 4'd9);
        end_writes();
        add_random_items(600);
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
        drain();

        repeat (200) @(posedge clk);
        $display("Covered %0d items (%0d cell reads), %0d scrolls, three register settings.",
                 n_items, n_reads, n_scrolls);
        if (fails == 0 && view_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #1_000_000_000;
        $display("Timeout with %0d results still expected.", view_q.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule
